FILE: design/ssc_pkg.sv
// Shared types, opcode constants and a helper function for the script opcode
// stream scanner. No dependencies; every other file of the block imports it.
`default_nettype none

package ssc_pkg;

  // Width of the saturating signature-operation counter.
  localparam int COUNT_BITS = 16;
  localparam int SIGOP_OUT_W = 16;

  // Opcode values of the standard script encoding that the decoder tests.
  localparam logic [7:0] OP_0               = 8'h00;
  localparam logic [7:0] OP_PUSH_LEN1       = 8'h4c;
  localparam logic [7:0] OP_PUSH_LEN2       = 8'h4d;
  localparam logic [7:0] OP_PUSH_LEN4       = 8'h4e;
  localparam logic [7:0] OP_1               = 8'h51;
  localparam logic [7:0] OP_16              = 8'h60;
  localparam logic [7:0] OP_N_BIAS          = 8'h50;
  localparam logic [7:0] OP_SIG_CHECK       = 8'hac;
  localparam logic [7:0] OP_SIG_CHECK_VFY   = 8'had;
  localparam logic [7:0] OP_MULTI_CHECK     = 8'hae;
  localparam logic [7:0] OP_CHECKMSIGVERIFY = 8'haf;
  localparam logic [7:0] OP_LAST_DEFINED    = 8'hb9;
  localparam logic [7:0] OP_INVALID         = 8'hff;

  // Configuration register indexes.
  localparam logic REG_ACCURATE_COUNT = 1'b0;
  localparam logic REG_MULTISIG_WORST = 1'b1;

  // Reset values of the configuration registers.
  localparam logic       ACCURATE_RESET = 1'b1;
  localparam logic [7:0] WORST_RESET    = 8'd20;

  // Bit positions of selected fields inside the result tdata word.
  localparam int TD_PARSE_ERROR   = 49;
  localparam int TD_ONLY_PUSHES   = 66;
  localparam int TD_ALL_OPS_VALID = 67;
  localparam int TDATA_W          = 72;

  typedef enum logic [1:0] {
    KIND_TOKEN = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t                  item_kind;
    logic [7:0]             op_code;
    logic [31:0]            push_length;
    logic [7:0]             payload_byte;
    logic                   payload_last;
    logic                   script_end;
    logic                   parse_error;
    logic [SIGOP_OUT_W-1:0] sigop_total;
    logic                   only_pushes;
    logic                   all_ops_valid;
  } result_t;

  typedef struct packed {
    logic       accurate_count;
    logic [7:0] multisig_worst_case;
  } cfg_t;

  // Number of little-endian length bytes that follow a PUSHDATA opcode.
  function automatic logic [2:0] length_width(input logic [7:0] op);
    logic [2:0] w;
    if (op == OP_PUSH_LEN1) begin
      w = 3'd1;
    end else if (op == OP_PUSH_LEN2) begin
      w = 3'd2;
    end else begin
      w = 3'd4;
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/ssc_step.sv
// Per-byte decoder of the script scanner: parse state registers plus the
// single-pass next-state and result logic. Depends on ssc_pkg.
`default_nettype none

module ssc_step
  import ssc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] script_byte,
  input  wire logic       last_byte,
  input  wire cfg_t       cfg,
  output logic            res_valid,
  output result_t         res
);

  typedef enum logic [1:0] {
    PH_OP   = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  phase_t                phase, phase_next;
  logic [7:0]            pending_opcode, pending_opcode_next;
  logic [31:0]           length_accum, length_accum_next;
  logic [2:0]            length_left, length_left_next;
  logic [31:0]           payload_left, payload_left_next;
  logic [7:0]            previous_opcode, previous_opcode_next;
  logic [COUNT_BITS-1:0] sigop_counter, sigop_counter_next;
  logic                  push_only_flag, push_only_flag_next;
  logic                  valid_flag, valid_flag_next;
  logic                  error_flag, error_flag_next;

  logic [2:0]          len_total;
  logic [2:0]          len_idx;
  logic [2:0]          len_left_dec;
  logic [31:0]         accum_or;
  logic [31:0]         payload_dec;
  logic                payload_is_last;
  logic [7:0]          sig_add;
  logic [COUNT_BITS:0] sig_sum;
  logic                err_set;
  logic                push_clr;
  logic                valid_clr;

  always_comb begin
    len_total = length_width(pending_opcode);
    if (length_left != 3'd0 && length_left <= len_total) begin
      len_idx = len_total - length_left;
    end else begin
      len_idx = 3'd0;
    end
    len_left_dec    = (length_left != 3'd0) ? length_left - 3'd1 : 3'd0;
    accum_or        = length_accum | ({24'd0, script_byte} << {len_idx[1:0], 3'b000});
    payload_dec     = (payload_left != 32'd0) ? payload_left - 32'd1 : 32'd0;
    payload_is_last = (payload_left <= 32'd1);
  end

  always_comb begin
    phase_next           = phase;
    pending_opcode_next  = pending_opcode;
    length_accum_next    = length_accum;
    length_left_next     = length_left;
    payload_left_next    = payload_left;
    previous_opcode_next = previous_opcode;
    res_valid            = 1'b0;
    res.item_kind        = KIND_TOKEN;
    res.op_code          = 8'd0;
    res.push_length      = 32'd0;
    res.payload_byte     = 8'd0;
    res.payload_last     = 1'b0;
    sig_add              = 8'd0;
    err_set              = 1'b0;
    push_clr             = 1'b0;
    valid_clr            = 1'b0;

    case (phase)
      PH_LEN: begin
        length_accum_next = accum_or;
        length_left_next  = len_left_dec;
        if (len_left_dec == 3'd0) begin
          previous_opcode_next = pending_opcode;
          res_valid            = 1'b1;
          if (accum_or == 32'd0) begin
            phase_next  = PH_OP;
            res.op_code = pending_opcode;
          end else if (last_byte) begin
            err_set       = 1'b1;
            res.item_kind = KIND_END;
          end else begin
            phase_next        = PH_DATA;
            payload_left_next = accum_or;
            res.op_code       = pending_opcode;
            res.push_length   = accum_or;
          end
        end else if (last_byte) begin
          err_set       = 1'b1;
          res_valid     = 1'b1;
          res.item_kind = KIND_END;
        end
      end
      PH_DATA: begin
        payload_left_next = payload_dec;
        if (payload_dec == 32'd0) begin
          phase_next = PH_OP;
        end else if (last_byte) begin
          err_set = 1'b1;
        end
        res_valid        = 1'b1;
        res.item_kind    = KIND_DATA;
        res.payload_byte = script_byte;
        res.payload_last = payload_is_last;
      end
      default: begin
        if (script_byte < OP_PUSH_LEN1) begin
          previous_opcode_next = script_byte;
          res_valid            = 1'b1;
          if (script_byte == OP_0) begin
            res.op_code = OP_0;
          end else if (last_byte) begin
            err_set       = 1'b1;
            res.item_kind = KIND_END;
          end else begin
            phase_next        = PH_DATA;
            payload_left_next = {24'd0, script_byte};
            res.op_code       = script_byte;
            res.push_length   = {24'd0, script_byte};
          end
        end else if (script_byte <= OP_PUSH_LEN4) begin
          pending_opcode_next = script_byte;
          length_accum_next   = 32'd0;
          length_left_next    = length_width(script_byte);
          phase_next          = PH_LEN;
          if (last_byte) begin
            err_set       = 1'b1;
            res_valid     = 1'b1;
            res.item_kind = KIND_END;
          end
        end else begin
          if (script_byte inside {OP_SIG_CHECK, OP_SIG_CHECK_VFY}) begin
            sig_add = 8'd1;
          end else if (script_byte inside {OP_MULTI_CHECK, OP_CHECKMSIGVERIFY}) begin
            if (cfg.accurate_count && (previous_opcode inside {[OP_1:OP_16]})) begin
              sig_add = previous_opcode - OP_N_BIAS;
            end else begin
              sig_add = cfg.multisig_worst_case;
            end
          end
          push_clr             = (script_byte > OP_16);
          valid_clr            = (script_byte > OP_LAST_DEFINED) && (script_byte != OP_INVALID);
          previous_opcode_next = script_byte;
          res_valid            = 1'b1;
          res.op_code          = script_byte;
        end
      end
    endcase

    // The addend stays below 256, so a carry out means the counter saturates.
    sig_sum = {1'b0, sigop_counter} + (COUNT_BITS + 1)'(sig_add);
    if (sig_sum[COUNT_BITS]) begin
      sigop_counter_next = '1;
    end else begin
      sigop_counter_next = sig_sum[COUNT_BITS-1:0];
    end
    error_flag_next     = error_flag | err_set;
    push_only_flag_next = push_only_flag & ~push_clr;
    valid_flag_next     = valid_flag & ~valid_clr;

    res.script_end    = last_byte;
    res.parse_error   = error_flag_next;
    res.sigop_total   = SIGOP_OUT_W'(sigop_counter_next);
    res.only_pushes   = push_only_flag_next & ~error_flag_next;
    res.all_ops_valid = valid_flag_next & ~error_flag_next;
  end

  // The final byte of a script returns the parser to its reset state.
  always_ff @(posedge clk) begin
    if (rst || (accept && last_byte)) begin
      phase           <= PH_OP;
      pending_opcode  <= 8'd0;
      length_accum    <= 32'd0;
      length_left     <= 3'd0;
      payload_left    <= 32'd0;
      previous_opcode <= OP_INVALID;
      sigop_counter   <= '0;
      push_only_flag  <= 1'b1;
      valid_flag      <= 1'b1;
      error_flag      <= 1'b0;
    end else if (accept) begin
      phase           <= phase_next;
      pending_opcode  <= pending_opcode_next;
      length_accum    <= length_accum_next;
      length_left     <= length_left_next;
      payload_left    <= payload_left_next;
      previous_opcode <= previous_opcode_next;
      sigop_counter   <= sigop_counter_next;
      push_only_flag  <= push_only_flag_next;
      valid_flag      <= valid_flag_next;
      error_flag      <= error_flag_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/ssc_out_reg.sv
// Result register of the script scanner: holds one result word and drives
// the input-side ready so a new byte enters whenever the slot frees up.
// Depends on ssc_pkg.
`default_nettype none

module ssc_out_reg
  import ssc_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    load,
  input  wire result_t load_data,
  output logic         slot_free,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= load_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/script_opcode_stream_scanner.sv
// Top level of the script opcode stream scanner: configuration registers,
// the per-byte decoder and the result register. Depends on ssc_pkg,
// ssc_step and ssc_out_reg.
//
// Usage. A script enters on the slave stream one byte per word: s_tdata is
// the script byte and s_tlast marks the final byte of the script. Each
// accepted byte gives zero or one result word on the master stream. Opcodes
// give a token (m_tuser = 0) once their push length is known, every pushed
// byte gives a payload word (m_tuser = 1), and a script cut short before a
// push's data begins gives an end-only word (m_tuser = 2) with the parse
// error set. A PUSHDATA1/2/4 opcode and all but its last length byte give no
// word unless they end the script; the last length byte gives the token.
// m_tlast marks the word that carries the end-of-script summary; after the
// final byte the parser state is cleared for the next script.
//
// A result shows on the master side in the cycle after its byte is accepted.
// Throughput is one byte per cycle, set by the single result register; a
// byte is taken whenever that register is empty or being read in the same
// cycle. When the receiver stalls, the held word stays put and s_tready
// drops until it is taken.
// Reset clears the parser and the result register and loads the register
// defaults (accurate multisig count on, worst case 20). Configuration is
// written through cfg_we/cfg_addr/cfg_wdata while no script is in flight.
`default_nettype none

module script_opcode_stream_scanner
  import ssc_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  // Script bytes in.
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  input  wire logic [7:0]         s_tdata,   // [7:0] script_byte
  input  wire logic               s_tlast,   // last_byte
  // Result words out.
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // [7:0] op_code, [39:8] push_length, [47:40] payload_byte,
  // [48] payload_last, [49] parse_error, [65:50] sigop_total,
  // [66] only_pushes, [67] all_ops_valid, [71:68] zero
  output logic [TDATA_W-1:0]      m_tdata,
  output logic [1:0]              m_tuser,   // [1:0] item_kind
  output logic                    m_tlast,   // script_end
  // Configuration writes.
  input  wire logic               cfg_we,
  input  wire logic               cfg_addr,
  input  wire logic [7:0]         cfg_wdata
);

  cfg_t    cfg;
  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  // Configuration registers; the write side has no handshake.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.accurate_count      <= ACCURATE_RESET;
      cfg.multisig_worst_case <= WORST_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ACCURATE_COUNT: cfg.accurate_count      <= cfg_wdata[0];
        REG_MULTISIG_WORST: cfg.multisig_worst_case <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept = s_tvalid && s_tready;

  ssc_step u_step (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .script_byte (s_tdata),
    .last_byte   (s_tlast),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  ssc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (accept && res_valid),
    .load_data (res),
    .slot_free (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_res)
  );

  assign m_tdata = {4'd0,
                    out_res.all_ops_valid,
                    out_res.only_pushes,
                    out_res.sigop_total,
                    out_res.parse_error,
                    out_res.payload_last,
                    out_res.payload_byte,
                    out_res.push_length,
                    out_res.op_code};
  assign m_tuser = out_res.item_kind;
  assign m_tlast = out_res.script_end;

endmodule

`default_nettype wire

FILE: design/ssc_checker.sv
// Port-level checks for the script opcode stream scanner and the bind that
// attaches them to the top level. Depends on ssc_pkg.
`default_nettype none

module ssc_checker
  import ssc_pkg::*;
(
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               m_tvalid,
  input wire logic               m_tready,
  input wire logic [TDATA_W-1:0] m_tdata,
  input wire logic [1:0]         m_tuser,
  input wire logic               m_tlast
);

  // A held result word does not change while the receiver stalls.
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result word changed under stall");

  // Nothing is offered in the cycle after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result offered right after reset");

  // An end-only word exists only for a truncated script.
  a_end_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_END) |-> m_tlast && m_tdata[TD_PARSE_ERROR])
    else $error("end-only word without error or end mark");

  // A parse error is reported only on the end word and clears both flags.
  a_error_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[TD_PARSE_ERROR] |->
      m_tlast && !m_tdata[TD_ONLY_PUSHES] && !m_tdata[TD_ALL_OPS_VALID])
    else $error("parse error with inconsistent summary");

  // Payload words carry no opcode and no push length.
  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == KIND_DATA) |-> (m_tdata[39:0] == 40'd0))
    else $error("payload word carries token fields");

endmodule

bind script_opcode_stream_scanner ssc_checker u_ssc_checker (.*);

`default_nettype wire

FILE: dv/ssc_scoreboard_pkg.sv
// Scoreboard class for the script opcode stream scanner testbench: a byte-level
// predictor of the scanner and an in-order checker of its result words.
// Depends on ssc_pkg for the opcode constants, field positions and result type.

package ssc_scoreboard_pkg;
  import ssc_pkg::*;

  typedef enum logic [1:0] {
    AWAIT_OP,
    GATHER_LEN,
    IN_PAYLOAD
  } scan_phase_t;

  class token_checker;
    // Register copies.
    logic                   accurate;
    logic [7:0]             worst;
    // Scanner state as the block keeps it.
    scan_phase_t            phase;
    logic [7:0]             pend_op;
    logic [31:0]            len_acc;
    logic [2:0]             len_left;
    logic [31:0]            pay_left;
    logic [7:0]             prev_op;
    logic [COUNT_BITS-1:0]  sigops;
    logic                   push_only;
    logic                   ops_valid;
    logic                   err;

    result_t                expected_words[$];
    int                     mismatches;
    int                     tokens;
    int                     data_words;
    int                     end_words;
    int                     truncations;
    int                     saturated;

    function new();
      accurate    = ACCURATE_RESET;
      worst       = WORST_RESET;
      mismatches  = 0;
      tokens      = 0;
      data_words  = 0;
      end_words   = 0;
      truncations = 0;
      saturated   = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      phase     = AWAIT_OP;
      pend_op   = OP_0;
      len_acc   = '0;
      len_left  = '0;
      pay_left  = '0;
      prev_op   = OP_INVALID;
      sigops    = '0;
      push_only = 1'b1;
      ops_valid = 1'b1;
      err       = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [7:0] value);
      if (idx == REG_ACCURATE_COUNT) begin
        accurate = value[0];
      end else begin
        worst = value;
      end
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    // The counter sticks at its all-ones value.
    function void add_sigops(logic [31:0] n);
      longint unsigned cap;
      longint unsigned sum;
      cap = (64'd1 << COUNT_BITS) - 64'd1;
      sum = 64'(sigops) + 64'(n);
      sigops = (sum > cap) ? cap[COUNT_BITS-1:0] : sum[COUNT_BITS-1:0];
    endfunction

    function void emit(kind_t kind, logic [7:0] op, logic [31:0] plen, logic [7:0] pb,
                       logic plast, logic fin);
      result_t r;
      r.item_kind     = kind;
      r.op_code       = op;
      r.push_length   = plen;
      r.payload_byte  = pb;
      r.payload_last  = plast;
      r.script_end    = fin;
      r.parse_error   = err;
      r.sigop_total   = SIGOP_OUT_W'(sigops);
      r.only_pushes   = push_only && !err;
      r.all_ops_valid = ops_valid && !err;
      expected_words.insert(expected_words.size(), r);
    endfunction

    // Works out the word, if any, that one accepted script byte causes.
    function void take_byte(logic [7:0] b, logic fin);
      logic [2:0] total;
      logic [2:0] left;
      logic [2:0] idx;
      logic       lastp;
      case (phase)
        GATHER_LEN: begin
          total = (pend_op == OP_PUSH_LEN1) ? 3'd1 : ((pend_op == OP_PUSH_LEN2) ? 3'd2 : 3'd4);
          left  = len_left;
          idx   = (left >= 3'd1 && left <= total) ? total - left : 3'd0;
          len_acc  = len_acc | ({24'd0, b} << (8 * idx[1:0]));
          len_left = (left > 3'd0) ? left - 3'd1 : 3'd0;
          if (len_left == 3'd0) begin
            prev_op = pend_op;
            if (len_acc == 32'd0) begin
              phase = AWAIT_OP;
              emit(KIND_TOKEN, pend_op, 32'd0, 8'd0, 1'b0, fin);
            end else if (fin) begin
              err = 1'b1;
              emit(KIND_END, 8'd0, 32'd0, 8'd0, 1'b0, 1'b1);
            end else begin
              phase    = IN_PAYLOAD;
              pay_left = len_acc;
              emit(KIND_TOKEN, pend_op, len_acc, 8'd0, 1'b0, 1'b0);
            end
          end else if (fin) begin
            err = 1'b1;
            emit(KIND_END, 8'd0, 32'd0, 8'd0, 1'b0, 1'b1);
          end
        end
        IN_PAYLOAD: begin
          lastp    = (pay_left <= 32'd1);
          pay_left = (pay_left > 32'd0) ? pay_left - 32'd1 : 32'd0;
          if (pay_left == 32'd0) begin
            phase = AWAIT_OP;
          end else if (fin) begin
            err = 1'b1;
          end
          emit(KIND_DATA, 8'd0, 32'd0, b, lastp, fin);
        end
        default: begin
          if (b < OP_PUSH_LEN1) begin
            prev_op = b;
            if (b == OP_0) begin
              emit(KIND_TOKEN, OP_0, 32'd0, 8'd0, 1'b0, fin);
            end else if (fin) begin
              err = 1'b1;
              emit(KIND_END, 8'd0, 32'd0, 8'd0, 1'b0, 1'b1);
            end else begin
              phase    = IN_PAYLOAD;
              pay_left = {24'd0, b};
              emit(KIND_TOKEN, b, {24'd0, b}, 8'd0, 1'b0, 1'b0);
            end
          end else if (b <= OP_PUSH_LEN4) begin
            pend_op  = b;
            len_acc  = '0;
            len_left = (b == OP_PUSH_LEN1) ? 3'd1 : ((b == OP_PUSH_LEN2) ? 3'd2 : 3'd4);
            phase    = GATHER_LEN;
            if (fin) begin
              err = 1'b1;
              emit(KIND_END, 8'd0, 32'd0, 8'd0, 1'b0, 1'b1);
            end
          end else begin
            if (b == OP_SIG_CHECK || b == OP_SIG_CHECK_VFY) begin
              add_sigops(32'd1);
            end else if (b == OP_MULTI_CHECK || b == OP_CHECKMSIGVERIFY) begin
              // A preceding OP_N gives the exact key count in accurate mode.
              if (accurate && prev_op >= OP_1 && prev_op <= OP_16) begin
                add_sigops({24'd0, prev_op - OP_N_BIAS});
              end else begin
                add_sigops({24'd0, worst});
              end
            end
            if (b > OP_16) begin
              push_only = 1'b0;
            end
            if (b > OP_LAST_DEFINED && b != OP_INVALID) begin
              ops_valid = 1'b0;
            end
            prev_op = b;
            emit(KIND_TOKEN, b, 32'd0, 8'd0, 1'b0, fin);
          end
        end
      endcase
      if (fin) begin
        clear_scan();
      end
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got, realtime stamp);
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 200) begin
          $display("%0.1f ns: %s mismatch, expected 0x%0h actual 0x%0h",
                   stamp, field, want, got);
        end else if (mismatches == 201) begin
          $display("%0.1f ns: further mismatch reports suppressed", stamp);
        end
      end
    endfunction

    // Checks one accepted result word against the oldest expectation.
    function void check_word(logic [1:0] kind, logic [TDATA_W-1:0] data, logic last,
                             realtime stamp);
      result_t want;
      if (expected_words.size() == 0) begin
        mismatches++;
        $display("%0.1f ns: unexpected word, expected none actual kind %0d data 0x%0h",
                 stamp, kind, data);
        return;
      end
      want = expected_words.pop_front();
      compare("item_kind", 32'(want.item_kind), 32'(kind), stamp);
      compare("op_code", 32'(want.op_code), 32'(data[7:0]), stamp);
      compare("push_length", want.push_length, data[39:8], stamp);
      compare("payload_byte", 32'(want.payload_byte), 32'(data[47:40]), stamp);
      compare("payload_last", 32'(want.payload_last), 32'(data[48]), stamp);
      compare("script_end", 32'(want.script_end), 32'(last), stamp);
      compare("parse_error", 32'(want.parse_error), 32'(data[TD_PARSE_ERROR]), stamp);
      compare("sigop_total", 32'(want.sigop_total), 32'(data[65:50]), stamp);
      compare("only_pushes", 32'(want.only_pushes), 32'(data[TD_ONLY_PUSHES]), stamp);
      compare("all_ops_valid", 32'(want.all_ops_valid), 32'(data[TD_ALL_OPS_VALID]), stamp);
      case (want.item_kind)
        KIND_TOKEN: tokens++;
        KIND_DATA:  data_words++;
        default:    end_words++;
      endcase
      if (want.parse_error) begin
        truncations++;
      end
      if (want.sigop_total == '1) begin
        saturated++;
      end
    endfunction
  endclass

endpackage

FILE: dv/script_opcode_stream_scanner_tb.sv
// Testbench top for the script opcode stream scanner: drives scripts byte by
// byte, stalls the result side and checks every word against a predictor.
// Depends on ssc_pkg and ssc_scoreboard_pkg, and on the block itself.

module script_opcode_stream_scanner_tb
  import ssc_pkg::*;
  import ssc_scoreboard_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The limit leaves a wide margin for a full run, even with heavy
  // stalls on both sides.
  localparam int CYCLE_LIMIT = 400000;

  // Opcodes the directed script uses that the package does not name.
  localparam logic [7:0] OP_NOP        = 8'h61;
  localparam logic [7:0] OP_UNDEFINED  = OP_LAST_DEFINED + 8'd1;
  localparam logic [7:0] MAX_DIRECT    = OP_PUSH_LEN1 - 8'd1;

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;
  logic               m_tlast;
  logic               cfg_we;
  logic               cfg_addr;
  logic [7:0]         cfg_wdata;

  token_checker pred = new();

  // Bytes of the script being built or sent.
  logic [7:0] script_q[$];
  int         burst_left = 0;
  int         bytes_sent = 0;
  int         scripts_sent = 0;
  int         settings_used = 0;
  int         cycle_count = 0;

  script_opcode_stream_scanner u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Every word the block hands over is checked at the edge that takes it.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      pred.check_word(m_tuser, m_tdata, m_tlast, $realtime);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // The receiver switches between a few stall patterns, each held for a
  // random stretch: always ready, mostly ready, mostly stalled, and ready in a
  // regular periodic pattern. The always-ready stretches give back-to-back traffic.
  initial begin
    int mode;
    int stretch;
    int tick;
    m_tready = 1'b0;
    mode = 0;
    stretch = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (stretch == 0) begin
        mode = $urandom_range(0, 3);
        stretch = $urandom_range(20, 80);
      end
      stretch--;
      tick++;
      case (mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= ($urandom_range(0, 3) == 0);
        default: m_tready <= (tick % 3 == 0);
      endcase
    end
  end

  // Offers one byte and holds it until the block takes it. The sender runs
  // in bursts; between bursts it may drop valid. Returns at the falling
  // edge after the byte was taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100) : $urandom_range(1, 12);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    pred.take_byte(b, fin);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_script();
    foreach (script_q[i]) begin
      send_byte(script_q[i], i == script_q.size() - 1);
    end
    scripts_sent++;
  endtask

  // Waits until every expected word is out. Scripts always end on a byte
  // that gives a word, so the block is idle once that word is taken.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pred.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    pred.set_reg(idx, value);
    @(negedge clk);
  endtask

  // Adds one byte at the end of the script being built.
  function automatic void append_byte(input logic [7:0] b);
    script_q.insert(script_q.size(), b);
  endfunction

  // Appends one well-formed element with random content, or a stray byte.
  function automatic void add_element();
    int          sel;
    int          n;
    logic [7:0]  op;
    logic [31:0] len;
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      append_byte(OP_0);
    end else if (sel < 30) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, MAX_DIRECT) : $urandom_range(1, 6);
      append_byte(8'(n));
      repeat (n) append_byte(8'($urandom));
    end else if (sel < 45) begin
      op = OP_PUSH_LEN1 + 8'($urandom_range(0, 2));
      if ($urandom_range(0, 14) == 0) begin
        len = (op == OP_PUSH_LEN1) ? $urandom_range(200, 255) : $urandom_range(200, 300);
      end else begin
        len = $urandom_range(0, 5);
      end
      append_byte(op);
      append_byte(len[7:0]);
      if (op != OP_PUSH_LEN1) begin
        append_byte(len[15:8]);
      end
      if (op == OP_PUSH_LEN4) begin
        append_byte(len[23:16]);
        append_byte(len[31:24]);
      end
      repeat (len) append_byte(8'($urandom));
    end else if (sel < 60) begin
      // Key count right before a multisig, the case the accurate mode reads.
      append_byte(OP_1 + 8'($urandom_range(0, 15)));
      append_byte($urandom_range(0, 1) ? OP_MULTI_CHECK : OP_CHECKMSIGVERIFY);
    end else if (sel < 72) begin
      append_byte(OP_SIG_CHECK + 8'($urandom_range(0, 3)));
    end else if (sel < 92) begin
      append_byte(8'($urandom_range(OP_PUSH_LEN4 + 1, 8'hff)));
    end else begin
      append_byte(8'($urandom));
    end
  endfunction

  // Most scripts are sequences of whole elements; some are cut short at a
  // random byte, which may land inside a length or a payload, and a few are
  // plain noise.
  function automatic void build_script();
    int n;
    int cut;
    script_q.delete();
    if ($urandom_range(0, 19) == 0) begin
      n = $urandom_range(1, 12);
      repeat (n) append_byte(8'($urandom));
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) add_element();
      if ($urandom_range(0, 4) == 0 && script_q.size() > 1) begin
        cut = $urandom_range(1, script_q.size() - 1);
        while (script_q.size() > cut) void'(script_q.pop_back());
      end
    end
  endfunction

  // One register setting, then random scripts until the byte budget is spent.
  task automatic run_phase(input logic acc, input logic [7:0] worst, input bit saturate,
                           input int budget);
    int start;
    settle();
    write_reg(REG_ACCURATE_COUNT, {7'd0, acc});
    write_reg(REG_MULTISIG_WORST, worst);
    settings_used++;
    if (saturate) begin
      // Enough multisig charges at the largest worst case to pin the counter.
      script_q.delete();
      repeat (260) append_byte(OP_MULTI_CHECK);
      append_byte(OP_SIG_CHECK);
      send_script();
    end
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      build_script();
      send_script();
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'd0;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = REG_ACCURATE_COUNT;
    cfg_wdata = 8'd0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    settings_used = 1;

    // Directed scripts under the reset register values. The first walks
    // through these opcode classes: empty push, a direct push, a zero-length
    // PUSHDATA1, a PUSHDATA2 with its data, an exact multisig count, a
    // plain checksig, an undefined opcode, the invalid opcode (still counted
    // as defined), the largest exact multisig count, and a non-push opcode.
    script_q = '{OP_0, 8'h01, 8'hff, OP_PUSH_LEN1, 8'h00,
                 OP_PUSH_LEN2, 8'h02, 8'h00, 8'haa, 8'h55,
                 OP_1 + 8'd1, OP_MULTI_CHECK, OP_SIG_CHECK, OP_UNDEFINED, OP_INVALID,
                 OP_16, OP_CHECKMSIGVERIFY, OP_NOP};
    send_script();
    // Script ends in the middle of a PUSHDATA4 length.
    script_q = '{OP_PUSH_LEN4, 8'h01, 8'h00};
    send_script();
    // Script ends inside a payload, so the error rides on a payload word.
    script_q = '{8'h03, 8'h11};
    send_script();
    // Script ends right on a PUSHDATA1 opcode.
    script_q = '{OP_PUSH_LEN1};
    send_script();
    // Script ends right on the longest direct push.
    script_q = '{MAX_DIRECT};
    send_script();

    run_phase(1'b0, 8'd0, 1'b0, 175);
    run_phase(1'b0, 8'd255, 1'b1, 150);
    run_phase(1'b1, 8'd255, 1'b0, 175);
    run_phase(1'b1, 8'd0, 1'b0, 175);
    run_phase(1'b0, 8'($urandom), 1'b0, 175);
    run_phase(1'b1, 8'($urandom), 1'b0, 175);

    settle();
    repeat (4) @(posedge clk);
    $display("covered %0d script bytes in %0d scripts under %0d register settings",
             bytes_sent, scripts_sent, settings_used);
    $display("checked %0d tokens, %0d payload words, %0d end-only words;",
             pred.tokens, pred.data_words, pred.end_words);
    $display("  %0d truncated, %0d saturated", pred.truncations, pred.saturated);
    if (pred.mismatches == 0 && pred.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
